[src/bmma_pkg.sv]
package bmma_pkg;

  // matrix dimension and derived sizes
  localparam int DIM    = 4;
  localparam int CELLS  = DIM * DIM;
  localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int FAC_W  = 16;
  localparam int INIT_W = 32;
  localparam int PROD_W = 2 * FAC_W;
  localparam int ACC_W  = 40;
  localparam int POS_W  = 3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_LOAD_C  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_WRITE
  } state_e;

  // sequencer to datapath and memories
  typedef struct packed {
    logic  a_we;
    logic  b_we;
    logic  c_we;
    logic  c_wsrc_load;
    addr_t wr_addr;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    addr_t rd_addr_c;
    logic  issue;
    logic  first;
    logic  emit;
    idx_t  emit_row;
    idx_t  emit_col;
    logic  emit_last;
  } ctrl_t;

  function automatic addr_t cell_addr(idx_t r, idx_t c);
    return addr_t'(r) * addr_t'(DIM) + addr_t'(c);
  endfunction

endpackage

[src/bmma_ram.sv]
module bmma_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bmma_mac.sv]
module bmma_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              issue_i,
  input  logic                              first_i,
  input  logic signed [bmma_pkg::FAC_W-1:0] a_i,
  input  logic signed [bmma_pkg::FAC_W-1:0] b_i,
  input  logic signed [bmma_pkg::ACC_W-1:0] init_i,
  output logic signed [bmma_pkg::ACC_W-1:0] acc_o,
  output logic                              busy_o
);

  logic                               rd_vld_q;
  logic                               rd_first_q;
  logic                               prod_vld_q;
  logic signed [bmma_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [bmma_pkg::ACC_W-1:0]  acc_d, acc_q;

  // memory data arrives in the cycle after the read was issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= issue_i;
      rd_first_q <= issue_i & first_i;
      prod_vld_q <= rd_vld_q;
    end
  end

  assign prod_d = a_i * b_i;

  always_comb begin
    acc_d = acc_q;
    if (rd_first_q) begin
      acc_d = init_i;
    end else if (prod_vld_q) begin
      acc_d = acc_q + bmma_pkg::ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = rd_vld_q | prod_vld_q;

endmodule

[src/bmma_ctrl.sv]
module bmma_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  command_i,
  input  logic [bmma_pkg::POS_W-1:0]  row_i,
  input  logic [bmma_pkg::POS_W-1:0]  col_i,
  input  logic                        busy_i,
  input  logic                        out_free_i,
  output bmma_pkg::ctrl_t             ctrl_o
);

  bmma_pkg::state_e state_d, state_q;
  bmma_pkg::idx_t   i_d, i_q, j_d, j_q, k_d, k_q;
  bmma_pkg::cmd_e   cmd;
  logic             accept;
  logic             in_range;
  logic             k_last;
  logic             elem_last;

  assign cmd       = bmma_pkg::cmd_e'(command_i);
  assign in_ready_o = (state_q == bmma_pkg::ST_IDLE);
  assign accept    = in_valid_i & in_ready_o;
  assign in_range  = ({1'b0, row_i} < 4'(bmma_pkg::DIM)) &&
                     ({1'b0, col_i} < 4'(bmma_pkg::DIM));
  assign k_last    = (k_q == bmma_pkg::idx_t'(bmma_pkg::DIM - 1));
  assign elem_last = (i_q == bmma_pkg::idx_t'(bmma_pkg::DIM - 1)) &&
                     (j_q == bmma_pkg::idx_t'(bmma_pkg::DIM - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmma_pkg::ST_IDLE: begin
        if (accept && cmd == bmma_pkg::CMD_COMPUTE) begin
          state_d = bmma_pkg::ST_ISSUE;
        end
      end
      bmma_pkg::ST_ISSUE: begin
        if (k_last) begin
          state_d = bmma_pkg::ST_DRAIN;
        end
      end
      bmma_pkg::ST_DRAIN: begin
        if (!busy_i) begin
          state_d = bmma_pkg::ST_WRITE;
        end
      end
      bmma_pkg::ST_WRITE: begin
        if (out_free_i) begin
          state_d = elem_last ? bmma_pkg::ST_IDLE : bmma_pkg::ST_ISSUE;
        end
      end
      default: state_d = bmma_pkg::ST_IDLE;
    endcase
  end

  // element and term counters
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    case (state_q)
      bmma_pkg::ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
      end
      bmma_pkg::ST_ISSUE: begin
        k_d = k_last ? '0 : k_q + bmma_pkg::idx_t'(1);
      end
      bmma_pkg::ST_WRITE: begin
        if (out_free_i) begin
          if (j_q == bmma_pkg::idx_t'(bmma_pkg::DIM - 1)) begin
            j_d = '0;
            i_d = i_q + bmma_pkg::idx_t'(1);
          end else begin
            j_d = j_q + bmma_pkg::idx_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o             = '0;
    ctrl_o.rd_addr_a   = bmma_pkg::cell_addr(i_q, k_q);
    ctrl_o.rd_addr_b   = bmma_pkg::cell_addr(k_q, j_q);
    ctrl_o.rd_addr_c   = bmma_pkg::cell_addr(i_q, j_q);
    ctrl_o.emit_row    = i_q;
    ctrl_o.emit_col    = j_q;
    ctrl_o.emit_last   = elem_last;
    ctrl_o.wr_addr     = bmma_pkg::cell_addr(i_q, j_q);
    case (state_q)
      bmma_pkg::ST_IDLE: begin
        ctrl_o.wr_addr     = bmma_pkg::cell_addr(row_i[bmma_pkg::IDX_W-1:0],
                                                 col_i[bmma_pkg::IDX_W-1:0]);
        ctrl_o.c_wsrc_load = 1'b1;
        if (accept && in_range) begin
          ctrl_o.a_we = (cmd == bmma_pkg::CMD_LOAD_A);
          ctrl_o.b_we = (cmd == bmma_pkg::CMD_LOAD_B);
          ctrl_o.c_we = (cmd == bmma_pkg::CMD_LOAD_C);
        end
      end
      bmma_pkg::ST_ISSUE: begin
        ctrl_o.issue = 1'b1;
        ctrl_o.first = (k_q == '0);
      end
      bmma_pkg::ST_WRITE: begin
        ctrl_o.emit = out_free_i;
        ctrl_o.c_we = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmma_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.emit |-> !busy_i)
    else $error("write-back while products still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.emit && ctrl_o.emit_last) |=> (state_q == bmma_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after last element");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.a_we, ctrl_o.b_we, ctrl_o.c_we}))
    else $error("more than one store written in a cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.c_we && ctrl_o.issue))
    else $error("accumulator write overlaps a read pass");
`endif

endmodule

[src/blocked_matrix_multiply_accumulate.sv]
// C += A * B on DIM-by-DIM signed integer matrices (DIM = 4 by default, set
// in bmma_pkg). Command 0, 1 and 2 write one element of A, B (16-bit) or C
// (32-bit, sign-extended to 40); a load whose row or column is not below DIM
// is dropped. Command 3 adds A*B into C and sends all DIM*DIM updated C
// elements in row-major order with last set on the final one; C keeps the
// sums, so a further compute accumulates again (wrapping at 40 bits). A and B
// must be written before a compute reads them; C starts at zero after reset,
// tracked by a valid bit per entry, so no clearing pass is needed. In a
// compute, one shared 16x16 multiply-accumulate steps through the dot
// product, fed by one read per cycle from each of the A and B memories; the
// pipeline then drains and C is written back. A stalled output holds the
// write-back. No input is taken while a compute runs.
module blocked_matrix_multiply_accumulate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic [bmma_pkg::POS_W-1:0]          row_i,
  input  logic [bmma_pkg::POS_W-1:0]          col_i,
  input  logic signed [bmma_pkg::FAC_W-1:0]   factor_value_i,
  input  logic signed [bmma_pkg::INIT_W-1:0]  start_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bmma_pkg::POS_W-1:0]          out_row_o,
  output logic [bmma_pkg::POS_W-1:0]          out_col_o,
  output logic signed [bmma_pkg::ACC_W-1:0]   sum_value_o,
  output logic                                last_o
);

  bmma_pkg::ctrl_t                   ctrl;
  logic                              busy;
  logic                              out_free;

  logic [bmma_pkg::FAC_W-1:0]        a_rdata;
  logic [bmma_pkg::FAC_W-1:0]        b_rdata;
  logic [bmma_pkg::ACC_W-1:0]        c_rdata;
  logic [bmma_pkg::ACC_W-1:0]        c_wdata;
  logic signed [bmma_pkg::ACC_W-1:0] c_init;
  logic signed [bmma_pkg::ACC_W-1:0] acc;

  // one valid bit per C entry: an entry never written reads as zero
  logic [bmma_pkg::CELLS-1:0]        cvld_q;
  logic                              cvld_rd_q;

  // output register
  logic                              out_valid_q;
  logic [bmma_pkg::POS_W-1:0]        out_row_q;
  logic [bmma_pkg::POS_W-1:0]        out_col_q;
  logic signed [bmma_pkg::ACC_W-1:0] sum_q;
  logic                              last_q;

  // the output register can take a new element when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  bmma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .busy_i     (busy),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // left factor A
  bmma_ram #(
    .Width (bmma_pkg::FAC_W),
    .Depth (bmma_pkg::CELLS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ctrl.a_we),
    .waddr_i (ctrl.wr_addr),
    .wdata_i (factor_value_i),
    .raddr_i (ctrl.rd_addr_a),
    .rdata_o (a_rdata)
  );

  // right factor B
  bmma_ram #(
    .Width (bmma_pkg::FAC_W),
    .Depth (bmma_pkg::CELLS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ctrl.b_we),
    .waddr_i (ctrl.wr_addr),
    .wdata_i (factor_value_i),
    .raddr_i (ctrl.rd_addr_b),
    .rdata_o (b_rdata)
  );

  // accumulator C: written by a load or by the write-back of a sum
  assign c_wdata = ctrl.c_wsrc_load ? bmma_pkg::ACC_W'(start_value_i) : acc;

  bmma_ram #(
    .Width (bmma_pkg::ACC_W),
    .Depth (bmma_pkg::CELLS)
  ) u_ram_c (
    .clk_i   (clk_i),
    .we_i    (ctrl.c_we),
    .waddr_i (ctrl.wr_addr),
    .wdata_i (c_wdata),
    .raddr_i (ctrl.rd_addr_c),
    .rdata_o (c_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q    <= '0;
      cvld_rd_q <= 1'b0;
    end else begin
      if (ctrl.c_we) begin
        cvld_q[ctrl.wr_addr] <= 1'b1;
      end
      // follows the registered read of the C memory
      cvld_rd_q <= cvld_q[ctrl.rd_addr_c];
    end
  end

  assign c_init = cvld_rd_q ? c_rdata : '0;

  // shared multiply-accumulate
  bmma_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (ctrl.issue),
    .first_i (ctrl.first),
    .a_i     (a_rdata),
    .b_i     (b_rdata),
    .init_i  (c_init),
    .acc_o   (acc),
    .busy_o  (busy)
  );

  // result transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_row_q <= bmma_pkg::POS_W'(ctrl.emit_row);
      out_col_q <= bmma_pkg::POS_W'(ctrl.emit_col);
      sum_q     <= acc;
      last_q    <= ctrl.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign sum_value_o = sum_q;
  assign last_o      = last_q;

endmodule
